>>> hw/rtl/bea_pkg.sv
`default_nettype none

package bea_pkg;

  localparam int unsigned BUTTON_COUNT = 8;
  localparam int unsigned MASK_W       = 8;
  localparam int unsigned COUNT_W      = 8;
  localparam int unsigned REG_DATA_W   = 8;
  localparam int unsigned REG_INDEX_W  = 1;

  typedef logic [MASK_W-1:0]      mask_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [REG_INDEX_W-1:0] reg_index_t;
  typedef logic [REG_DATA_W-1:0]  reg_data_t;

  localparam reg_index_t REG_REPEAT_DELAY = 1'd0;
  localparam reg_index_t REG_REPEAT_RATE  = 1'd1;

  localparam count_t REPEAT_DELAY_RESET = 8'd20;
  localparam count_t REPEAT_RATE_RESET  = 8'd6;

  // Raw serial bit that drives each logical button bit.
  localparam mask_t RAW_BIT_FOR_LOGICAL [BUTTON_COUNT] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
  };

  function automatic mask_t permute_pad(input mask_t raw);
    mask_t logical;
    logical = '0;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      logical[i] = |(raw & RAW_BIT_FOR_LOGICAL[i]);
    end
    return logical;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bea_stream_if.sv
`default_nettype none

interface bea_pad_if;
  logic              valid;
  logic              ready;
  bea_pkg::mask_t    pad_raw;

  modport source (output valid, output pad_raw, input ready);
  modport sink   (input valid, input pad_raw, output ready);
endinterface

interface bea_buttons_if;
  logic              valid;
  logic              ready;
  bea_pkg::mask_t    held_mask;
  bea_pkg::mask_t    previous_mask;
  bea_pkg::mask_t    pressed_mask;
  bea_pkg::mask_t    released_mask;
  bea_pkg::mask_t    repeat_mask;

  modport source (
    output valid, output held_mask, output previous_mask, output pressed_mask,
    output released_mask, output repeat_mask, input ready
  );
  modport sink (
    input valid, input held_mask, input previous_mask, input pressed_mask,
    input released_mask, input repeat_mask, output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/button_edge_and_autorepeat_core.sv
`default_nettype none

// Button edge detector with per-button auto-repeat. Each pad transaction carries one raw
// controller byte; one buttons transaction follows with the held, previous, pressed,
// released and repeat masks. A transaction is accepted every cycle while the output
// register is empty or being drained. The button state and the eight repeat counters
// update at acceptance. A press is reported in repeat_mask at once; a held button then
// pulses after repeat_delay + 1 further transactions and every repeat_rate + 1
// transactions after that. Registers are written through wr_en, wr_index and wr_data
// (index 0 repeat_delay, index 1 repeat_rate) by the user only while the block is idle,
// which the block does not enforce; a new value takes effect at the next counter reload.
module button_edge_and_autorepeat_core (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   wr_en,
  input  wire bea_pkg::reg_index_t wr_index,
  input  wire bea_pkg::reg_data_t  wr_data,
  bea_pad_if.sink               pad,
  bea_buttons_if.source         buttons
);

  import bea_pkg::*;

  count_t repeat_delay;
  count_t repeat_rate;
  mask_t  last_held;
  count_t countdown [BUTTON_COUNT];
  count_t countdown_next [BUTTON_COUNT];

  mask_t  held;
  mask_t  pressed;
  mask_t  released;
  mask_t  repeat_next;
  logic   accept;

  assign pad.ready = !buttons.valid || buttons.ready;
  assign accept    = pad.valid && pad.ready;

  assign held     = permute_pad(pad.pad_raw);
  assign pressed  = held & ~last_held;
  assign released = last_held & ~held;

  always_comb begin
    repeat_next = pressed;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (!held[i] || pressed[i]) begin
        countdown_next[i] = repeat_delay;
      end else if (countdown[i] != '0) begin
        countdown_next[i] = countdown[i] - 1'b1;
      end else begin
        countdown_next[i] = repeat_rate;
        repeat_next[i]    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay <= REPEAT_DELAY_RESET;
      repeat_rate  <= REPEAT_RATE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_REPEAT_DELAY: repeat_delay <= wr_data;
        REG_REPEAT_RATE:  repeat_rate  <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_held <= '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        countdown[i] <= REPEAT_DELAY_RESET;
      end
    end else if (accept) begin
      last_held <= held;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        countdown[i] <= countdown_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buttons.valid <= 1'b0;
    end else if (pad.ready) begin
      buttons.valid <= pad.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buttons.held_mask     <= held;
      buttons.previous_mask <= last_held;
      buttons.pressed_mask  <= pressed;
      buttons.released_mask <= released;
      buttons.repeat_mask   <= repeat_next;
    end
  end

  a_edges_disjoint: assert property (@(posedge clk) disable iff (rst)
    buttons.valid |-> (buttons.pressed_mask & buttons.released_mask) == '0)
    else $error("pressed and released masks overlap");

  a_press_repeats: assert property (@(posedge clk) disable iff (rst)
    buttons.valid |-> (buttons.pressed_mask & ~buttons.repeat_mask) == '0)
    else $error("a new press is missing from the repeat mask");

  a_history_tracks: assert property (@(posedge clk) disable iff (rst)
    accept |=> last_held == buttons.held_mask)
    else $error("held history does not match the last result");

  a_drain_frees: assert property (@(posedge clk) disable iff (rst)
    !buttons.valid |-> pad.ready)
    else $error("input stalled while the output register is empty");

endmodule

`default_nettype wire

>>> bench/tb_button_edge_and_autorepeat_core.sv
`default_nettype none

module tb_button_edge_and_autorepeat_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bea_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned LONG_HOLDOFF = 100;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned REPORT_LIMIT = 50;

  typedef struct packed {
    mask_t held_mask;
    mask_t previous_mask;
    mask_t pressed_mask;
    mask_t released_mask;
    mask_t repeat_mask;
  } button_result_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       wr_en;
  reg_index_t wr_index;
  reg_data_t  wr_data;

  bea_pad_if     pad_ch ();
  bea_buttons_if buttons_ch ();

  button_result_t expected_buttons [$];
  mask_t          held_last;
  count_t         repeat_count [BUTTON_COUNT];
  count_t         delay_cfg;
  count_t         rate_cfg;
  int unsigned    mismatches;
  int unsigned    stall_cycles;
  int unsigned    max_gap;
  bit             holdoff_req;

  button_edge_and_autorepeat_core u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pad      (pad_ch),
    .buttons  (buttons_ch)
  );

  always #10 clk = ~clk;

  function automatic button_result_t predict_buttons(mask_t raw);
    button_result_t r;
    mask_t          held;
    // The serial read order already matches the logical button layout.
    held = raw;
    r.held_mask     = held;
    r.previous_mask = held_last;
    r.pressed_mask  = held & ~held_last;
    r.released_mask = held_last & ~held;
    r.repeat_mask   = r.pressed_mask;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (!held[i] || r.pressed_mask[i]) begin
        repeat_count[i] = delay_cfg;
      end else if (repeat_count[i] != '0) begin
        repeat_count[i] = repeat_count[i] - 1'b1;
      end else begin
        r.repeat_mask[i] = 1'b1;
        repeat_count[i]  = rate_cfg;
      end
    end
    held_last = held;
    return r;
  endfunction

  task automatic check_field(string name, mask_t want, mask_t got);
    if (want !== got) begin
      if (mismatches < REPORT_LIMIT) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    button_result_t want;
    if (rst) begin
      held_last = '0;
      delay_cfg = REPEAT_DELAY_RESET;
      rate_cfg  = REPEAT_RATE_RESET;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        repeat_count[i] = REPEAT_DELAY_RESET;
      end
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_REPEAT_DELAY: delay_cfg = wr_data;
          REG_REPEAT_RATE:  rate_cfg  = wr_data;
          default: ;
        endcase
      end
      if (pad_ch.valid && pad_ch.ready) begin
        expected_buttons.push_back(predict_buttons(pad_ch.pad_raw));
      end
      if (buttons_ch.valid && buttons_ch.ready) begin
        if (expected_buttons.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("%0t: unexpected buttons transaction, expected none, actual held %h",
                     $time, buttons_ch.held_mask);
          end
          mismatches++;
        end else begin
          want = expected_buttons.pop_front();
          check_field("held_mask", want.held_mask, buttons_ch.held_mask);
          check_field("previous_mask", want.previous_mask, buttons_ch.previous_mask);
          check_field("pressed_mask", want.pressed_mask, buttons_ch.pressed_mask);
          check_field("released_mask", want.released_mask, buttons_ch.released_mask);
          check_field("repeat_mask", want.repeat_mask, buttons_ch.repeat_mask);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pad_ch.valid && pad_ch.ready) || (buttons_ch.valid && buttons_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned gap;
    buttons_ch.ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (holdoff_req) begin
        buttons_ch.ready <= 1'b0;
        repeat (LONG_HOLDOFF) @(negedge clk);
        holdoff_req = 1'b0;
      end else begin
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
          buttons_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      buttons_ch.ready <= 1'b1;
      do @(posedge clk); while (!(buttons_ch.valid && buttons_ch.ready) && !holdoff_req);
      @(negedge clk);
    end
  end

  task automatic send_pad(mask_t raw);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      pad_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pad_ch.valid   <= 1'b1;
    pad_ch.pad_raw <= raw;
    do @(posedge clk); while (!pad_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    pad_ch.valid <= 1'b0;
    while (expected_buttons.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_repeat_timing(reg_data_t delay, reg_data_t rate);
    wr_en    <= 1'b1;
    wr_index <= REG_REPEAT_DELAY;
    wr_data  <= delay;
    @(negedge clk);
    wr_index <= REG_REPEAT_RATE;
    wr_data  <= rate;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic run_button_bursts(int unsigned n_items, int unsigned max_hold,
                                   int unsigned flip_odds);
    mask_t       pad_bits;
    logic [2:0]  flip_bit;
    int unsigned sent;
    int unsigned hold_len;
    sent = 0;
    while (sent < n_items) begin
      pad_bits = mask_t'($urandom);
      hold_len = $urandom_range(1, max_hold);
      for (int unsigned k = 0; k < hold_len && sent < n_items; k++) begin
        if ($urandom_range(0, flip_odds) == 0) begin
          flip_bit = 3'($urandom_range(0, MASK_W - 1));
          pad_bits[flip_bit] ^= 1'b1;
        end
        if ($urandom_range(0, 2 * flip_odds) == 0) begin
          send_pad(mask_t'($urandom));
        end else begin
          send_pad(pad_bits);
        end
        sent++;
      end
    end
  endtask

  task automatic test_edges();
    send_pad(8'h00);
    send_pad(8'hFF);
    send_pad(8'h00);
    for (int i = 0; i < MASK_W; i++) begin
      send_pad(mask_t'(1) << i);
    end
    send_pad(8'hAA);
    send_pad(8'h55);
    send_pad(8'h00);
    wait_drain();
  endtask

  task automatic test_zero_timing();
    set_repeat_timing(8'd0, 8'd0);
    repeat (5) send_pad(8'hFF);
    send_pad(8'h00);
    wait_drain();
  endtask

  // Counters keep running across a register write; the new values show up at reload.
  task automatic test_write_while_counting();
    set_repeat_timing(8'd3, 8'd2);
    repeat (2) send_pad(8'h81);
    wait_drain();
    set_repeat_timing(8'd255, 8'd255);
    repeat (4) send_pad(8'h81);
    wait_drain();
  endtask

  task automatic test_random_settings();
    reg_data_t delays [7];
    reg_data_t rates  [7];
    delays = '{8'd20, 8'd0, 8'd1, 8'd0, 8'd255, 8'd0, 8'd0};
    rates  = '{8'd6, 8'd0, 8'd0, 8'd1, 8'd0, 8'd255, 8'd0};
    delays[5] = reg_data_t'($urandom_range(0, 12));
    delays[6] = reg_data_t'($urandom_range(0, 12));
    rates[6]  = reg_data_t'($urandom_range(0, 12));
    for (int p = 0; p < 7; p++) begin
      set_repeat_timing(delays[p], rates[p]);
      run_button_bursts(55, 40, 7);
      wait_drain();
    end
    set_repeat_timing(reg_data_t'($urandom), reg_data_t'($urandom));
    run_button_bursts(40, 40, 7);
    wait_drain();
  endtask

  task automatic test_back_to_back();
    max_gap = 0;
    set_repeat_timing(8'd2, 8'd1);
    run_button_bursts(60, 20, 5);
    wait_drain();
    max_gap = 9;
  endtask

  task automatic test_output_backpressure();
    set_repeat_timing(8'd4, 8'd3);
    holdoff_req = 1'b1;
    max_gap = 0;
    run_button_bursts(40, 20, 5);
    max_gap = 9;
    wait_drain();
  endtask

  task automatic test_long_hold_extremes();
    set_repeat_timing(8'd255, 8'd255);
    run_button_bursts(350, 340, 2000);
    wait_drain();
  endtask

  initial begin
    rst          = 1'b1;
    wr_en        = 1'b0;
    wr_index     = REG_REPEAT_DELAY;
    wr_data      = '0;
    pad_ch.valid   = 1'b0;
    pad_ch.pad_raw = '0;
    mismatches   = 0;
    stall_cycles = 0;
    max_gap      = 9;
    holdoff_req  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_edges();
    test_zero_timing();
    test_write_while_counting();
    test_random_settings();
    test_back_to_back();
    test_output_backpressure();
    test_long_hold_extremes();

    wait_drain();
    if (mismatches == 0 && expected_buttons.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
